// File: hw/rtl/bcfa_pkg.sv
// Shared types and constants for the contiguous frame allocator.
// Used by every module of the allocator core; depends on nothing.
package bcfa_pkg;

	localparam int unsigned NumFramesDefault = 4096;
	localparam int unsigned WordWidth = 64;
	localparam int unsigned QueueDepth = 2;

	localparam logic [1:0] StOk      = 2'd0;
	localparam logic [1:0] StNoSpace = 2'd1;
	localparam logic [1:0] StZero    = 2'd2;
	localparam logic [1:0] StClipped = 2'd3;

	localparam logic KindAlloc = 1'b0;
	localparam logic KindFree  = 1'b1;

	localparam logic CfgSearchStart = 1'b0;
	localparam logic CfgSearchEnd   = 1'b1;

	// Command handed from the front end to the execution engine.
	typedef struct packed {
		logic        is_free;
		logic        is_zero;
		logic [11:0] base_frame;
		logic [12:0] count;
	} cmd_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_SCAN,
		EX_CLEAR,
		EX_FILL,
		EX_DONE
	} ex_state_t;

endpackage

// File: hw/rtl/bitmap_contiguous_frame_allocator_core.sv
// Top level of the contiguous frame allocator core.
// Depends on bcfa_pkg, bcfa_front and bcfa_engine.
//
// One free bit per 4 KiB frame, 1 meaning free, held in a memory of 64-bit
// words that is cleared to all allocated by a pass over every word after
// reset, during which the engine takes no command. Each item yields exactly
// one result. Work is done one frame at a time through the single memory
// port: an allocate scans frames and then clears the run that it found, a
// free sets its frames, and a zero count touches no frame.
// A two-entry command queue in front lets items arrive while one executes.
module bitmap_contiguous_frame_allocator_core #(
	parameter int unsigned NUM_FRAMES = bcfa_pkg::NumFramesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // base_frame[11:0], count[24:12]
	input  logic        s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // status[1:0], run_base[13:2]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	logic           cmd_valid;
	logic           cmd_ready;
	bcfa_pkg::cmd_t cmd;
	logic [11:0]    search_start_q;
	logic [12:0]    search_end_q;
	logic [1:0]     status;
	logic [11:0]    run_base;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_start_q <= '0;
			search_end_q   <= 13'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				bcfa_pkg::CfgSearchStart: search_start_q <= cfg_data[11:0];
				bcfa_pkg::CfgSearchEnd:   search_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	bcfa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.kind       (s_axis_tuser),
		.base_frame (s_axis_tdata[11:0]),
		.count      (s_axis_tdata[24:12]),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	bcfa_engine #(.NUM_FRAMES(NUM_FRAMES)) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.search_start (search_start_q),
		.search_end   (search_end_q),
		.res_valid    (m_axis_tvalid),
		.res_ready    (m_axis_tready),
		.res_status   (status),
		.res_run_base (run_base)
	);

	assign m_axis_tdata = {2'b00, run_base, status};

endmodule

// File: hw/rtl/bcfa_front.sv
// Front end: accepts items, classifies them and queues commands.
// Depends on bcfa_pkg.
module bcfa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [11:0]         base_frame,
	input  logic [12:0]         count,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output bcfa_pkg::cmd_t      cmd
);

	bcfa_pkg::cmd_t entry_q [bcfa_pkg::QueueDepth];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           push;
	logic           pop;

	assign in_ready  = (fill_q != 2'(bcfa_pkg::QueueDepth));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = entry_q[rd_ptr_q];

	// Queue storage; classification is done on the way in.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q].is_free    <= (kind == bcfa_pkg::KindFree);
			entry_q[wr_ptr_q].is_zero    <= (count == 13'd0);
			entry_q[wr_ptr_q].base_frame <= base_frame;
			entry_q[wr_ptr_q].count      <= count;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= 2'(bcfa_pkg::QueueDepth))
		else $error("queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> fill_q == $past(fill_q) + 2'd1)
		else $error("fill count lost a push");
	assert property (@(posedge clk) disable iff (!arst_n) fill_q == 2'd0 |-> !pop)
		else $error("pop from empty queue");

endmodule

// File: hw/rtl/bcfa_engine.sv
// Execution engine: owns the free map as a word memory, scans and updates it.
// Depends on bcfa_pkg.
module bcfa_engine #(
	parameter int unsigned NUM_FRAMES = bcfa_pkg::NumFramesDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  bcfa_pkg::cmd_t cmd,
	input  logic [11:0]    search_start,
	input  logic [12:0]    search_end,
	output logic           res_valid,
	input  logic           res_ready,
	output logic [1:0]     res_status,
	output logic [11:0]    res_run_base
);

	localparam int unsigned WW = bcfa_pkg::WordWidth;
	localparam int unsigned NumWords = (NUM_FRAMES + WW - 1) / WW;
	localparam int unsigned FW = $clog2(NUM_FRAMES + 1);
	localparam int unsigned AW = (NumWords > 1) ? $clog2(NumWords) : 1;
	localparam int unsigned BW = $clog2(WW);
	localparam int unsigned CW = (FW > 13) ? FW : 13;

	typedef logic [WW-1:0] word_t;

	word_t                 mem_q [NumWords];
	word_t                 rd_word_q;
	logic   [AW:0]         clr_addr_q;
	logic                  clr_busy_q;

	bcfa_pkg::ex_state_t   state_q, state_d;
	logic   [CW:0]         pos_q;      // current frame
	logic   [CW:0]         last_q;     // one past last frame of the walk
	logic   [CW:0]         run_q;
	logic   [CW:0]         run_start_q;
	logic   [12:0]         need_q;
	logic                  rd_ok_q;
	logic   [1:0]          status_q;
	logic   [11:0]         base_q;
	logic                  out_valid_q;

	logic   [CW:0]         eff_end;
	logic   [CW:0]         free_last;
	logic                  bit_now;
	logic   [AW-1:0]       word_idx;
	logic   [BW-1:0]       bit_idx;
	logic                  wr_en;
	word_t                 wr_word;
	logic   [AW-1:0]       rd_addr;
	logic                  accept;

	assign eff_end = ({{(CW-12){1'b0}}, search_end} > (CW+1)'(NUM_FRAMES))
		? (CW+1)'(NUM_FRAMES) : (CW+1)'(search_end);
	assign free_last = ((CW+1)'(cmd.base_frame) + (CW+1)'(cmd.count) > (CW+1)'(NUM_FRAMES))
		? (CW+1)'(NUM_FRAMES) : (CW+1)'(cmd.base_frame) + (CW+1)'(cmd.count);

	assign word_idx = AW'(pos_q >> BW);
	assign bit_idx  = pos_q[BW-1:0];
	assign bit_now  = rd_word_q[bit_idx];
	assign accept   = cmd_valid && cmd_ready;
	assign cmd_ready = (state_q == bcfa_pkg::EX_IDLE) && !clr_busy_q && !out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bcfa_pkg::EX_IDLE: begin
				if (accept) begin
					if (cmd.is_zero) state_d = bcfa_pkg::EX_DONE;
					else if (cmd.is_free) state_d = bcfa_pkg::EX_FILL;
					else state_d = bcfa_pkg::EX_SCAN;
				end
			end
			bcfa_pkg::EX_SCAN: begin
				if (pos_q >= last_q) state_d = bcfa_pkg::EX_DONE;
				else if (rd_ok_q && bit_now && (run_q + 1'b1 == (CW+1)'(need_q)))
					state_d = bcfa_pkg::EX_CLEAR;
			end
			bcfa_pkg::EX_CLEAR, bcfa_pkg::EX_FILL: begin
				if (pos_q >= last_q) state_d = bcfa_pkg::EX_DONE;
			end
			bcfa_pkg::EX_DONE: state_d = bcfa_pkg::EX_IDLE;
			default: state_d = bcfa_pkg::EX_IDLE;
		endcase
	end

	// Memory port control: one read and one read-modify-write per frame, or a write of zero per word while clearing.
	always_comb begin
		wr_en   = 1'b0;
		wr_word = rd_word_q;
		rd_addr = word_idx;
		if (clr_busy_q) begin
			wr_en   = 1'b1;
			wr_word = '0;
		end else if ((state_q == bcfa_pkg::EX_CLEAR || state_q == bcfa_pkg::EX_FILL)
				&& rd_ok_q && pos_q < last_q) begin
			wr_en = 1'b1;
			wr_word[bit_idx] = (state_q == bcfa_pkg::EX_FILL);
		end
	end

	// Free map memory with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[clr_busy_q ? clr_addr_q[AW-1:0] : word_idx] <= wr_word;
		rd_word_q <= mem_q[rd_addr];
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == (AW+1)'(NumWords - 1)) clr_busy_q <= 1'b0;
		end
	end

	// Walk control. A read is valid in the cycle after the address settles; each
	// frame has an address step, then a use step, and writes land on the same word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcfa_pkg::EX_IDLE;
			out_valid_q <= 1'b0;
			rd_ok_q     <= 1'b0;
			pos_q       <= '0;
			last_q      <= '0;
			run_q       <= '0;
			run_start_q <= '0;
			need_q      <= '0;
			status_q    <= bcfa_pkg::StOk;
			base_q      <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && res_ready) out_valid_q <= 1'b0;
			case (state_q)
				bcfa_pkg::EX_IDLE: begin
					rd_ok_q <= 1'b0;
					run_q   <= '0;
					need_q  <= cmd.count;
					if (accept) begin
						base_q <= '0;
						if (cmd.is_zero) begin
							status_q <= bcfa_pkg::StZero;
						end else if (cmd.is_free) begin
							pos_q    <= (CW+1)'(cmd.base_frame);
							last_q   <= free_last;
							status_q <= ((CW+1)'(cmd.base_frame) + (CW+1)'(cmd.count)
								> (CW+1)'(NUM_FRAMES)) ? bcfa_pkg::StClipped : bcfa_pkg::StOk;
						end else begin
							pos_q    <= (CW+1)'(search_start);
							last_q   <= eff_end;
							status_q <= bcfa_pkg::StNoSpace;
						end
					end
				end
				bcfa_pkg::EX_SCAN: begin
					rd_ok_q <= ~rd_ok_q;
					if (rd_ok_q) begin
						if (!bit_now) begin
							run_q <= '0;
							pos_q <= pos_q + 1'b1;
						end else begin
							if (run_q == '0) run_start_q <= pos_q;
							if (run_q + 1'b1 == (CW+1)'(need_q)) begin
								status_q <= bcfa_pkg::StOk;
								base_q   <= (run_q == '0) ? 12'(pos_q) : 12'(run_start_q);
								last_q   <= pos_q + 1'b1;
								pos_q    <= (run_q == '0) ? pos_q : run_start_q;
							end else begin
								pos_q <= pos_q + 1'b1;
							end
							run_q <= run_q + 1'b1;
						end
					end
				end
				bcfa_pkg::EX_CLEAR, bcfa_pkg::EX_FILL: begin
					rd_ok_q <= ~rd_ok_q;
					if (rd_ok_q) pos_q <= pos_q + 1'b1;
				end
				bcfa_pkg::EX_DONE: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Result register outputs.
	always_comb begin
		res_valid    = out_valid_q;
		res_status   = status_q;
		res_run_base = base_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n) clr_busy_q |-> !cmd_ready)
		else $error("command taken during clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_ready |=> out_valid_q && $stable(status_q) && $stable(base_q))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bcfa_pkg::EX_CLEAR |-> status_q == bcfa_pkg::StOk)
		else $error("clear without successful scan");

endmodule
